// ----- design/assert_macros.svh -----
// Assertion macros used by the console writer datapath.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/tcw_pkg.sv -----
// Shared types and constants for the text console writer.
// No dependencies; every other design file but assert_macros.svh imports this package.
package tcw_pkg;

  localparam int unsigned COLS_DEFAULT = 80;
  localparam int unsigned ROWS_DEFAULT = 25;

  localparam int unsigned CMD_W  = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned CELL_W = ATTR_W + CHAR_W;

  localparam logic [CHAR_W-1:0] NEWLINE_CODE     = 8'h0A;
  localparam logic [CHAR_W-1:0] SPACE_CODE       = 8'h20;
  localparam logic [ATTR_W-1:0] BLANK_ATTR_RESET = 8'h07;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUT   = 2'd0,
    CMD_SET   = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // Where a sweep over the cell store begins.
  typedef enum logic [1:0] {
    SWEEP_ALL      = 2'd0,
    SWEEP_COPY     = 2'd1,
    SWEEP_LAST_ROW = 2'd2
  } sweep_start_e;

  typedef struct packed {
    logic         take_item;
    logic         cur_set;
    logic         cur_clear;
    logic         cur_advance;
    logic         put_write;
    logic         rd_cell;
    logic         sweep_load;
    sweep_start_e sweep_start;
    logic         copy_rd;
    logic         fill_wr;
    logic         out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    cmd_e command;
    logic is_newline;
    logic scroll_needed;
    logic sweep_last;
    logic out_busy;
  } ctrl_status_t;

endpackage

// ----- design/tcw_in_if.sv -----
// Command channel of the console writer: valid/ready plus the command fields.
// Depends on tcw_pkg for field widths.
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [CHAR_W-1:0] char_code;
  logic [ATTR_W-1:0] attribute;
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;

  modport source (output valid, command, char_code, attribute, col, row, input ready);
  modport sink   (input valid, command, char_code, attribute, col, row, output ready);
endinterface

// ----- design/tcw_out_if.sv -----
// Result channel of the console writer: valid/ready plus cursor and cell data.
// Depends on tcw_pkg for field widths.
interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [COL_W-1:0]  caret_col;
  logic [ROW_W-1:0]  caret_row;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, caret_col, caret_row, cell_data, input ready);
  modport sink   (input valid, caret_col, caret_row, cell_data, output ready);
endinterface

// ----- design/tcw_datapath.sv -----
// Datapath: item registers, cursor, cell store, sweep counter, result register.
// Depends on tcw_pkg and assert_macros.svh; driven by tcw_ctrl.
`include "assert_macros.svh"

module tcw_datapath import tcw_pkg::*; #(
  parameter int unsigned COLS = COLS_DEFAULT,
  parameter int unsigned ROWS = ROWS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [CHAR_W-1:0] char_code_i,
  input  logic [ATTR_W-1:0] attribute_i,
  input  logic [COL_W-1:0]  col_i,
  input  logic [ROW_W-1:0]  row_i,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  input  ctrl_cmd_t         ctrl_i,
  output ctrl_status_t      status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [COL_W-1:0]  caret_col_o,
  output logic [ROW_W-1:0]  caret_row_o,
  output logic [CELL_W-1:0] cell_data_o
);

  localparam int unsigned CELLS  = ROWS * COLS;
  localparam int unsigned ADDR_W = $clog2(CELLS);
  localparam logic [COL_W:0]    ColsLim   = (COL_W+1)'(COLS);
  localparam logic [ROW_W:0]    RowsLim   = (ROW_W+1)'(ROWS);
  localparam logic [COL_W-1:0]  LastCol   = COL_W'(COLS - 1);
  localparam logic [ROW_W-1:0]  LastRow   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] ColsAddr  = ADDR_W'(COLS);
  localparam logic [ADDR_W-1:0] LastAddr  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] LastRowAd = ADDR_W'((ROWS - 1) * COLS);

  // Latched item
  cmd_e              cmd_q;
  logic [CHAR_W-1:0] char_q;
  logic [ATTR_W-1:0] attr_q;
  logic [COL_W-1:0]  col_q;
  logic [ROW_W-1:0]  row_q;

  logic [ATTR_W-1:0] blank_attr_q;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [ADDR_W-1:0] sweep_q, sweep_d;
  logic              copy_pend_q;
  logic [ADDR_W-1:0] copy_dst_q;

  logic [CELL_W-1:0] mem_q [CELLS];
  logic [CELL_W-1:0] rd_data_q;

  logic              out_valid_q;
  logic [COL_W-1:0]  out_col_q;
  logic [ROW_W-1:0]  out_row_q;
  logic [CELL_W-1:0] out_data_q;

  logic [COL_W-1:0]  col_clamp;
  logic [ROW_W-1:0]  row_clamp;
  logic [ADDR_W-1:0] cur_addr, item_addr, rd_addr, wr_addr;
  logic [CELL_W-1:0] wr_data;
  logic              wr_en, rd_en;
  logic              is_newline, at_last_col, at_last_row, line_end;

  assign col_clamp = ({1'b0, col_i} >= ColsLim) ? LastCol : col_i;
  assign row_clamp = ({1'b0, row_i} >= RowsLim) ? LastRow : row_i;

  assign cur_addr  = ADDR_W'(ADDR_W'(cur_row_q) * ColsAddr) + ADDR_W'(cur_col_q);
  assign item_addr = ADDR_W'(ADDR_W'(row_q) * ColsAddr) + ADDR_W'(col_q);

  assign is_newline  = (char_q == NEWLINE_CODE);
  assign at_last_col = (cur_col_q == LastCol);
  assign at_last_row = (cur_row_q == LastRow);
  assign line_end    = is_newline || at_last_col;

  assign status_o.command       = cmd_q;
  assign status_o.is_newline    = is_newline;
  assign status_o.scroll_needed = line_end && at_last_row;
  assign status_o.sweep_last    = (sweep_q == LastAddr);
  assign status_o.out_busy      = out_valid_q && !out_ready_i;

  // Cursor update
  always_comb begin
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    if (ctrl_i.cur_set) begin
      cur_col_d = col_q;
      cur_row_d = row_q;
    end else if (ctrl_i.cur_clear) begin
      cur_col_d = '0;
      cur_row_d = '0;
    end else if (ctrl_i.cur_advance) begin
      if (line_end) begin
        cur_col_d = '0;
        // On the last row the scroll that follows keeps the cursor there.
        cur_row_d = at_last_row ? cur_row_q : cur_row_q + ROW_W'(1);
      end else begin
        cur_col_d = cur_col_q + COL_W'(1);
      end
    end
  end

  // Sweep counter
  always_comb begin
    sweep_d = sweep_q;
    if (ctrl_i.sweep_load) begin
      case (ctrl_i.sweep_start)
        SWEEP_ALL:      sweep_d = '0;
        SWEEP_COPY:     sweep_d = ColsAddr;
        SWEEP_LAST_ROW: sweep_d = LastRowAd;
        default:        sweep_d = '0;
      endcase
    end else if (ctrl_i.copy_rd || ctrl_i.fill_wr) begin
      sweep_d = sweep_q + ADDR_W'(1);
    end
  end

  // Single write port: copy write-back, blank fill, or put.
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = cur_addr;
    wr_data = {attr_q, char_q};
    if (copy_pend_q) begin
      wr_addr = copy_dst_q;
      wr_data = rd_data_q;
    end else if (ctrl_i.fill_wr) begin
      wr_addr = sweep_q;
      wr_data = {blank_attr_q, SPACE_CODE};
    end else if (!ctrl_i.put_write) begin
      wr_en = 1'b0;
    end
  end

  assign rd_en   = ctrl_i.copy_rd || ctrl_i.rd_cell;
  assign rd_addr = ctrl_i.copy_rd ? sweep_q : item_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // Item and payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.take_item) begin
      cmd_q  <= cmd_e'(command_i);
      char_q <= char_code_i;
      attr_q <= attribute_i;
      col_q  <= col_clamp;
      row_q  <= row_clamp;
    end
    copy_dst_q <= sweep_q - ColsAddr;
    sweep_q    <= sweep_d;
    if (ctrl_i.out_load) begin
      out_col_q  <= cur_col_q;
      out_row_q  <= cur_row_q;
      out_data_q <= (cmd_q == CMD_READ) ? rd_data_q : '0;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blank_attr_q <= BLANK_ATTR_RESET;
      cur_col_q    <= '0;
      cur_row_q    <= '0;
      copy_pend_q  <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        blank_attr_q <= cfg_wdata_i;
      end
      cur_col_q   <= cur_col_d;
      cur_row_q   <= cur_row_d;
      copy_pend_q <= ctrl_i.copy_rd;
      if (ctrl_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign caret_col_o = out_col_q;
  assign caret_row_o = out_row_q;
  assign cell_data_o = out_data_q;

  `TCW_ASSERT_NOW(a_cursor_in_range, 1'b1,
    ({1'b0, cur_col_q} < ColsLim) && ({1'b0, cur_row_q} < RowsLim),
    "cursor left the screen")
  `TCW_ASSERT_NOW(a_one_writer, copy_pend_q, !ctrl_i.fill_wr && !ctrl_i.put_write,
    "two writers on the cell store port")
  `TCW_ASSERT_NOW(a_copy_src, ctrl_i.copy_rd, sweep_q >= ColsAddr,
    "scroll copy reads above the second row")
  `TCW_ASSERT_NOW(a_no_overwrite, ctrl_i.out_load, !(out_valid_q && !out_ready_i),
    "result register loaded while a result is pending")

endmodule

// ----- design/tcw_ctrl.sv -----
// Controller state machine: sequences put, set, clear, read and scroll sweeps.
// Depends on tcw_pkg; drives tcw_datapath through ctrl_cmd_t.
module tcw_ctrl import tcw_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  ctrl_status_t status_i,
  output ctrl_cmd_t    ctrl_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_DRAIN,
    ST_FILL,
    ST_DONE
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    ctrl_o  = '0;
    ctrl_o.sweep_start = SWEEP_ALL;
    case (state_q)
      ST_IDLE: begin
        // Take the item only on a real handshake; ready is low right after reset.
        if (in_valid_i && in_ready_o) begin
          ctrl_o.take_item = 1'b1;
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status_i.command)
          CMD_PUT: begin
            ctrl_o.put_write   = !status_i.is_newline;
            ctrl_o.cur_advance = 1'b1;
            if (status_i.scroll_needed) begin
              ctrl_o.sweep_load  = 1'b1;
              ctrl_o.sweep_start = SWEEP_COPY;
              state_d = ST_COPY;
            end else begin
              state_d = ST_DONE;
            end
          end
          CMD_SET: begin
            ctrl_o.cur_set = 1'b1;
            state_d = ST_DONE;
          end
          CMD_CLEAR: begin
            ctrl_o.cur_clear   = 1'b1;
            ctrl_o.sweep_load  = 1'b1;
            ctrl_o.sweep_start = SWEEP_ALL;
            state_d = ST_FILL;
          end
          CMD_READ: begin
            ctrl_o.rd_cell = 1'b1;
            state_d = ST_DONE;
          end
          default: state_d = ST_DONE;
        endcase
      end
      ST_COPY: begin
        ctrl_o.copy_rd = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Last copy write-back lands here; set up the bottom-row fill.
        ctrl_o.sweep_load  = 1'b1;
        ctrl_o.sweep_start = SWEEP_LAST_ROW;
        state_d = ST_FILL;
      end
      ST_FILL: begin
        ctrl_o.fill_wr = 1'b1;
        if (status_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!status_i.out_busy) begin
          ctrl_o.out_load = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      in_ready_o <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_ready_o <= (state_d == ST_IDLE);
    end
  end

endmodule

// ----- design/text_console_writer_unit.sv -----
// Top level of the text console writer: channel adapters, controller, datapath.
// Depends on tcw_pkg, tcw_in_if, tcw_out_if, tcw_ctrl and tcw_datapath.
//
// Usage:
//   cmd_i is a valid/ready channel carrying one command per transaction:
//   put character, set cursor, clear screen or read cell. rsp_o returns
//   exactly one transaction per command with the cursor after the command
//   and, for read cell, the addressed cell (attribute high, character low).
//   cfg_we_i/cfg_wdata_i write the blank attribute used by clear and scroll;
//   write it only while no command is in flight.
// Sequencing:
//   Set cursor, read cell and a put that does not scroll load the result
//   register from the done state; cmd_i reopens as it is loaded, so a new
//   command is taken only once the previous one has finished.
//   A clear sweeps the cell store once.
//   A put that scrolls copies (ROWS-1)*COLS cells, one per cycle through the
//   store's one read and one write port, then blanks the bottom row.
// Reset:
//   Clears the cursor and sets the blank attribute to 7. The cell store is
//   not cleared; issue a clear before reading cells.
// Back-pressure:
//   A finished result waits in the output register while the next command
//   is accepted and executed; only the loading of the next result holds
//   until rsp_o.ready takes the pending one.
module text_console_writer_unit import tcw_pkg::*; #(
  parameter int unsigned COLS = COLS_DEFAULT,
  parameter int unsigned ROWS = ROWS_DEFAULT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  tcw_in_if.sink            cmd_i,
  tcw_out_if.source         rsp_o,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i
);

  ctrl_cmd_t    ctrl;
  ctrl_status_t status;

  // Sequence each command through the datapath.
  tcw_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (cmd_i.valid),
    .in_ready_o (cmd_i.ready),
    .status_i   (status),
    .ctrl_o     (ctrl)
  );

  // Hold the cell store, cursor and result register.
  tcw_datapath #(
    .COLS (COLS),
    .ROWS (ROWS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .command_i   (cmd_i.command),
    .char_code_i (cmd_i.char_code),
    .attribute_i (cmd_i.attribute),
    .col_i       (cmd_i.col),
    .row_i       (cmd_i.row),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .ctrl_i      (ctrl),
    .status_o    (status),
    .out_ready_i (rsp_o.ready),
    .out_valid_o (rsp_o.valid),
    .caret_col_o (rsp_o.caret_col),
    .caret_row_o (rsp_o.caret_row),
    .cell_data_o (rsp_o.cell_data)
  );

endmodule
